>>> src/erd_pkg.sv
package erd_pkg;

	localparam int unsigned QueueDepthDefault = 2;

	localparam logic [7:0]  EscapeReset     = 8'd0;
	localparam logic [7:0]  HeaderLenReset  = 8'd18;
	localparam logic [15:0] OutputSizeReset = 16'd33694;

	typedef enum logic [1:0] {
		CFG_ESCAPE     = 2'd0,
		CFG_HEADER_LEN = 2'd1,
		CFG_SIZE_LIMIT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_DONE  = 2'd1,
		ST_TRUNC = 2'd2,
		ST_SHORT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_LITERAL = 2'd0,
		PH_COUNT   = 2'd1,
		PH_VALUE   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_SKIP  = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_TRUNC = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] value;
		logic [7:0] count;
		logic       last;
	} erd_cmd_t;

endpackage

>>> src/erd_front.sv
module erd_front import erd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] stream_byte,
	input  logic       last_byte,
	input  logic [7:0] escape_byte,
	input  logic [7:0] header_length,
	output erd_cmd_t   cmd
);

	phase_t     phase_q, phase_d;
	logic [7:0] pending_q, pending_d;
	logic [7:0] header_seen_q, header_seen_d;

	always_comb begin
		phase_d       = phase_q;
		pending_d     = pending_q;
		header_seen_d = header_seen_q;
		cmd.kind      = CMD_SKIP;
		cmd.value     = stream_byte;
		cmd.count     = 8'd1;
		cmd.last      = last_byte;
		if (header_seen_q < header_length) begin
			header_seen_d = header_seen_q + 8'd1;
			cmd.kind      = CMD_DATA;
		end else begin
			case (phase_q)
				PH_COUNT: begin
					pending_d = stream_byte;
					phase_d   = PH_VALUE;
					cmd.kind  = last_byte ? CMD_TRUNC : CMD_SKIP;
				end
				PH_VALUE: begin
					cmd.kind  = CMD_DATA;
					cmd.count = pending_q;
					phase_d   = PH_LITERAL;
					pending_d = 8'd0;
				end
				default: begin
					if (stream_byte == escape_byte) begin
						phase_d  = PH_COUNT;
						cmd.kind = last_byte ? CMD_TRUNC : CMD_SKIP;
					end else begin
						phase_d  = PH_LITERAL;
						cmd.kind = CMD_DATA;
					end
				end
			endcase
		end
		// end of stream always starts the next one clean
		if (last_byte) begin
			phase_d       = PH_LITERAL;
			pending_d     = 8'd0;
			header_seen_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LITERAL;
			pending_q     <= 8'd0;
			header_seen_q <= 8'd0;
		end else if (accept) begin
			phase_q       <= phase_d;
			pending_q     <= pending_d;
			header_seen_q <= header_seen_d;
		end
	end

endmodule

>>> src/erd_queue.sv
module erd_queue import erd_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepthDefault
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  erd_cmd_t push_cmd,
	input  logic     pop,
	output erd_cmd_t head_cmd,
	output logic     empty,
	output logic     full
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	erd_cmd_t        entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == FullCnt);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCnt)
		else $error("queue count out of range");

endmodule

>>> src/erd_back.sv
module erd_back import erd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_avail,
	input  erd_cmd_t    cmd,
	output logic        cmd_pop,
	input  logic [15:0] size_limit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  run_value,
	output logic [7:0]  run_length,
	output status_t     status
);

	logic        finished_q, finished_d;
	logic [15:0] produced_q, produced_d;
	logic        out_valid_q;
	logic [7:0]  value_q, length_q;
	status_t     status_q;

	logic        emit;
	logic [7:0]  emit_value, emit_len;
	status_t     emit_status;
	logic [15:0] room, sum;
	logic [7:0]  run_n;
	logic        use_data;

	assign cmd_pop = cmd_avail && (!out_valid_q || !out_stall);

	// clamp the run to the space left in the output
	assign room  = size_limit - produced_q;
	assign run_n = ({8'd0, cmd.count} > room) ? room[7:0] : cmd.count;

	always_comb begin
		finished_d  = finished_q;
		produced_d  = produced_q;
		emit        = 1'b0;
		emit_value  = 8'd0;
		emit_len    = 8'd0;
		emit_status = ST_DATA;
		use_data    = 1'b0;
		sum         = produced_q;
		if (finished_q) begin
			// drop everything up to the end of the stream
			if (cmd.last) begin
				finished_d = 1'b0;
				produced_d = 16'd0;
			end
		end else if (produced_q >= size_limit) begin
			use_data = 1'b1;
		end else begin
			case (cmd.kind)
				CMD_TRUNC: begin
					emit        = 1'b1;
					emit_status = ST_TRUNC;
					produced_d  = 16'd0;
				end
				CMD_DATA: begin
					use_data   = 1'b1;
					emit_len   = run_n;
					emit_value = (run_n != 8'd0) ? cmd.value : 8'd0;
					sum        = produced_q + {8'd0, run_n};
				end
				default: ;
			endcase
		end
		if (use_data) begin
			produced_d = sum;
			if (sum >= size_limit) begin
				emit        = 1'b1;
				emit_status = ST_DONE;
				if (cmd.last) begin
					produced_d = 16'd0;
				end else begin
					finished_d = 1'b1;
				end
			end else if (cmd.last) begin
				emit        = 1'b1;
				emit_status = ST_SHORT;
				produced_d  = 16'd0;
			end else begin
				emit = (emit_len != 8'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q  <= 1'b0;
			produced_q  <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				finished_q  <= finished_d;
				produced_q  <= produced_d;
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && emit) begin
			value_q  <= emit_value;
			length_q <= emit_len;
			status_q <= emit_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign run_value  = value_q;
	assign run_length = length_q;
	assign status     = status_q;

	a_zero_len_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && length_q == 8'd0) |-> value_q == 8'd0)
		else $error("empty run carries a value");
	a_trunc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_TRUNC) |-> length_q == 8'd0)
		else $error("truncation result carries data");
	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_DATA) |-> length_q != 8'd0)
		else $error("data result with zero length");
	a_produced_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && !finished_q && produced_q < size_limit) |=>
		(produced_q <= $past(size_limit)))
		else $error("produced count overran output size");

endmodule

>>> src/escape_rle_stream_decoder.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   stream_byte, last_byte
// output    out        out_valid / out_stall run_value, run_length, status
// config    in         cfg_we                cfg_index, cfg_data
//
// One compressed byte per cycle is taken while in_stall is low; a result is registered
// in the queue and then in the output register (front classify into the queue, back
// clamp + output reg). The back end clamps and counts combinationally to keep pace.
// in_stall rises only when the command queue fills behind a result held by out_stall;
// the output register frees the back end whenever it holds no result or out_stall is low.
// Reset clears the stream state and loads the register defaults.
module escape_rle_stream_decoder import erd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  run_value,
	output logic [7:0]  run_length,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  escape_q;
	logic [7:0]  header_len_q;
	logic [15:0] size_limit_q;

	logic     in_accept;
	erd_cmd_t front_cmd, head_cmd;
	logic     q_empty, q_full, q_pop;
	status_t  status_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q     <= EscapeReset;
			header_len_q <= HeaderLenReset;
			size_limit_q <= OutputSizeReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ESCAPE:     escape_q     <= cfg_data[7:0];
				CFG_HEADER_LEN: header_len_q <= cfg_data[7:0];
				CFG_SIZE_LIMIT: size_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	erd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.stream_byte   (stream_byte),
		.last_byte     (last_byte),
		.escape_byte   (escape_q),
		.header_length (header_len_q),
		.cmd           (front_cmd)
	);

	erd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_accept),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	erd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (!q_empty),
		.cmd        (head_cmd),
		.cmd_pop    (q_pop),
		.size_limit (size_limit_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.run_value  (run_value),
		.run_length (run_length),
		.status     (status_w)
	);

	assign status = status_w;

endmodule

>>> tb/sv/tb_escape_rle_stream_decoder.sv
`timescale 1ns / 1ps

module tb_escape_rle_stream_decoder;
	import erd_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int ItemTarget  = 800;
	localparam int DrainCycles = 12;
	localparam int MaxPrinted  = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_req_t;

	typedef struct packed {
		logic [7:0] value;
		logic [7:0] length;
		status_t    st;
	} run_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  stream_byte = 8'd0;
	logic        last_byte   = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [7:0]  run_value;
	logic [7:0]  run_length;
	logic [1:0]  status;
	logic        cfg_we      = 1'b0;
	logic [1:0]  cfg_index   = 2'd0;
	logic [15:0] cfg_data    = 16'd0;

	byte_req_t byte_reqs[$];
	byte_req_t stream_buf[$];
	run_t      expected_runs[$];
	byte_req_t next_req;
	run_t      got_run;

	int err_count    = 0;
	int cycles       = 0;
	int queued_bytes = 0;
	int burst_left   = 0;
	int gap_left     = 0;
	int stall_mode   = 0;
	int stall_left   = 0;

	// register copies and stream state of the decoder as predicted
	logic [7:0]  esc_reg      = EscapeReset;
	logic [7:0]  hdr_len_reg  = HeaderLenReset;
	logic [15:0] out_size_reg = OutputSizeReset;
	phase_t      dec_phase    = PH_LITERAL;
	logic [7:0]  run_count    = 8'd0;
	logic [15:0] produced     = 16'd0;
	logic [7:0]  hdr_seen     = 8'd0;
	logic        done_flag    = 1'b0;

	escape_rle_stream_decoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stream_byte (stream_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.run_value   (run_value),
		.run_length  (run_length),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("** escape_rle_stream_decoder: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		err_count++;
		if (err_count <= MaxPrinted)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	function automatic void clear_stream();
		dec_phase = PH_LITERAL;
		run_count = 8'd0;
		produced  = 16'd0;
		hdr_seen  = 8'd0;
		done_flag = 1'b0;
	endfunction

	function automatic void push_run(logic [7:0] value, logic [7:0] length, status_t st);
		run_t r;
		r.value  = (length != 8'd0) ? value : 8'd0;
		r.length = length;
		r.st     = st;
		expected_runs.push_back(r);
	endfunction

	// account for produced data, then decide between done, short end and plain data
	function automatic void settle_run(logic [7:0] value, logic [7:0] length, logic last);
		produced = produced + 16'(length);
		if (produced >= out_size_reg) begin
			if (last)
				clear_stream();
			else
				done_flag = 1'b1;
			push_run(value, length, ST_DONE);
		end else if (last) begin
			clear_stream();
			push_run(value, length, ST_SHORT);
		end else if (length != 8'd0) begin
			push_run(value, length, ST_DATA);
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic last);
		int room;
		if (done_flag) begin
			if (last)
				clear_stream();
		end else if (produced >= out_size_reg) begin
			settle_run(8'd0, 8'd0, last);
		end else if (hdr_seen < hdr_len_reg) begin
			hdr_seen = hdr_seen + 8'd1;
			settle_run(b, 8'd1, last);
		end else if (dec_phase == PH_COUNT) begin
			run_count = b;
			dec_phase = PH_VALUE;
			if (last) begin
				clear_stream();
				push_run(8'd0, 8'd0, ST_TRUNC);
			end
		end else if (dec_phase == PH_VALUE) begin
			// clamp the run to the space left
			room = int'(out_size_reg) - int'(produced);
			dec_phase = PH_LITERAL;
			settle_run(b, (int'(run_count) > room) ? 8'(room) : run_count, last);
			run_count = 8'd0;
		end else if (b == esc_reg) begin
			dec_phase = PH_COUNT;
			if (last) begin
				clear_stream();
				push_run(8'd0, 8'd0, ST_TRUNC);
			end
		end else begin
			dec_phase = PH_LITERAL;
			settle_run(b, 8'd1, last);
		end
	endfunction

	// request driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
			esc_reg      = EscapeReset;
			hdr_len_reg  = HeaderLenReset;
			out_size_reg = OutputSizeReset;
			clear_stream();
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				decode_byte(stream_byte, last_byte);
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (byte_reqs.size() > 0) begin
				next_req = byte_reqs.pop_front();
				in_valid    <= 1'b1;
				stream_byte <= next_req.data;
				last_byte   <= next_req.last;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_runs.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d length %0d status %0d",
						run_value, run_length, status));
				end else begin
					got_run = expected_runs.pop_front();
					if (run_value !== got_run.value)
						report_mismatch($sformatf("run_value %0d, expected %0d",
							run_value, got_run.value));
					if (run_length !== got_run.length)
						report_mismatch($sformatf("run_length %0d, expected %0d",
							run_length, got_run.length));
					if (status !== got_run.st)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, got_run.st));
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 150);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ((cycles % 6) < 2);
			endcase
		end
	end

	function automatic void add_byte(logic [7:0] b);
		byte_req_t r;
		r.data = b;
		r.last = 1'b0;
		stream_buf.push_back(r);
	endfunction

	function automatic void flush_stream(logic mark_last);
		if (mark_last)
			stream_buf[stream_buf.size() - 1].last = 1'b1;
		queued_bytes += stream_buf.size();
		while (stream_buf.size() > 0)
			byte_reqs.push_back(stream_buf.pop_front());
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [15:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ESCAPE:     esc_reg = d[7:0];
			CFG_HEADER_LEN: hdr_len_reg = d[7:0];
			CFG_SIZE_LIMIT: out_size_reg = d;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [7:0] esc, logic [7:0] hdr_len, logic [15:0] out_size);
		write_reg(CFG_ESCAPE, {8'd0, esc});
		write_reg(CFG_HEADER_LEN, {8'd0, hdr_len});
		write_reg(CFG_SIZE_LIMIT, out_size);
	endtask

	// hold until every request is taken and every result is back, then let the pipe settle
	task automatic wait_idle();
		while (byte_reqs.size() != 0 || in_valid || expected_runs.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic queue_stream();
		int kind;
		int est;
		int toks;
		int n;
		logic [7:0] cnt;
		logic [7:0] lit;
		kind = $urandom_range(0, 19);
		est  = 0;
		if (kind == 0) begin
			// noise: random bytes with the odd end flag
			n = $urandom_range(1, 30);
			repeat (n) begin
				add_byte(8'($urandom));
				stream_buf[stream_buf.size() - 1].last = ($urandom_range(0, 7) == 0);
			end
			flush_stream(1'b0);
		end else if (kind == 1 && hdr_len_reg != 8'd0) begin
			// end inside the header
			repeat ($urandom_range(1, hdr_len_reg)) add_byte(8'($urandom));
			flush_stream(1'b1);
		end else begin
			repeat (hdr_len_reg) add_byte(8'($urandom));
			est  = int'(hdr_len_reg);
			toks = (kind <= 7 || out_size_reg > 16'd2000) ? $urandom_range(0, 15) : 1 << 30;
			while (toks > 0 && est < int'(out_size_reg)) begin
				if ($urandom_range(0, 2) == 0) begin
					lit = 8'($urandom);
					add_byte((lit == esc_reg) ? ~lit : lit);
					est++;
				end else begin
					cnt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8))
						: 8'($urandom);
					add_byte(esc_reg);
					add_byte(cnt);
					add_byte(8'($urandom));
					est += int'(cnt);
				end
				toks--;
			end
			if (kind == 2 || kind == 3) begin
				// cut after the escape or after the count
				add_byte(esc_reg);
				if (kind == 3)
					add_byte(8'($urandom));
				flush_stream(1'b1);
			end else if (kind == 4) begin
				// leave the stream open across the next register change
				flush_stream(1'b0);
			end else begin
				if (est >= int'(out_size_reg))
					repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
				if (stream_buf.size() == 0)
					add_byte(8'($urandom));
				flush_stream(1'b1);
			end
		end
	endtask

	initial begin
		int phase_no;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_regs(8'h00, 8'd2, 16'd256);
		// header holding the escape value, literal, zero count, clamped run, dropped tail
		add_byte(8'h00); add_byte(8'hFF); add_byte(8'h7F);
		add_byte(8'h00); add_byte(8'h00); add_byte(8'h55);
		add_byte(8'h00); add_byte(8'hFF); add_byte(8'hAA);
		add_byte(8'h12); add_byte(8'h34);
		flush_stream(1'b1);
		// end within the header
		add_byte(8'h10); add_byte(8'h20);
		flush_stream(1'b1);
		// end right after the escape
		add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
		flush_stream(1'b1);
		wait_idle();

		set_regs(8'hFF, 8'd0, 16'hFFFF);
		add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h80);
		add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h81);
		flush_stream(1'b0);
		wait_idle();

		// lower the size below what the open stream has produced
		write_reg(CFG_SIZE_LIMIT, 16'd256);
		add_byte(8'h00); add_byte(8'h01);
		flush_stream(1'b1);
		// complete on the flagged byte
		add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h42); add_byte(8'h43);
		flush_stream(1'b1);
		// zero count with the value byte flagged last
		add_byte(8'hFF); add_byte(8'h00); add_byte(8'h7E);
		flush_stream(1'b1);
		// end right after the count
		add_byte(8'hFF); add_byte(8'h07);
		flush_stream(1'b1);
		wait_idle();

		queued_bytes = 0;
		for (phase_no = 0; queued_bytes < ItemTarget; phase_no++) begin
			case (phase_no)
				0: set_regs(8'h00, 8'd0, 16'd256);
				1: set_regs(8'hFF, 8'd255, 16'd256);
				2: set_regs(8'($urandom), 8'($urandom_range(0, 8)), 16'hFFFF);
				default: set_regs(8'($urandom),
					($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)),
					($urandom_range(0, 3) == 0) ? 16'($urandom_range(256, 65535))
						: 16'($urandom_range(256, 800)));
			endcase
			repeat ((phase_no == 1) ? 1 : $urandom_range(1, 4)) queue_stream();
			wait_idle();
		end

		if (err_count == 0)
			$display("** escape_rle_stream_decoder: PASSED **");
		else
			$display("** escape_rle_stream_decoder: FAILED **");
		$finish;
	end

endmodule
